// ===== rtl/priority_rule_matcher_over_history_unit_assert.svh =====
// Assertion macros shared by the priority rule matcher RTL.
`ifndef PRIORITY_RULE_MATCHER_OVER_HISTORY_UNIT_ASSERT_SVH
`define PRIORITY_RULE_MATCHER_OVER_HISTORY_UNIT_ASSERT_SVH

// Checks that a condition implies a consequence on every clock edge outside reset.
`define PRMH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence at the next clock edge.
`define PRMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prmh_pkg.sv =====
// Package with types, constants and helpers of the priority rule matcher.
`timescale 1ns / 1ps
`default_nettype none
package prmh_pkg;

    localparam int SETS             = 3;
    localparam int POSITIONS        = 8;
    localparam int HISTORY_DEPTH    = 16;
    localparam int MAX_LOGICS       = 8;
    localparam int MAX_CONDITIONS   = 4;
    localparam int MAX_OBSERVATIONS = 4;
    localparam int NTARGETS         = SETS * POSITIONS;
    localparam int NLOGICS          = NTARGETS * MAX_LOGICS;
    localparam int NCONDS           = NLOGICS * MAX_CONDITIONS;
    localparam int NOBS             = NCONDS * MAX_OBSERVATIONS;
    localparam int HIST_WORDS       = HISTORY_DEPTH * NTARGETS;
    localparam int OBS_W            = 17;

    localparam logic [2:0] CMD_STORE   = 3'd0;
    localparam logic [2:0] CMD_COMMIT  = 3'd1;
    localparam logic [2:0] CMD_OBS     = 3'd2;
    localparam logic [2:0] CMD_OCNT    = 3'd3;
    localparam logic [2:0] CMD_CCNT    = 3'd4;
    localparam logic [2:0] CMD_OUTCOME = 3'd5;
    localparam logic [2:0] CMD_LCNT    = 3'd6;
    localparam logic [2:0] CMD_QUERY   = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EVICTED  = 2'd1;
    localparam logic [1:0] ST_FUTURE   = 2'd2;
    localparam logic [1:0] ST_NO_LOGIC = 2'd3;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [1:0]        target_set;
        logic [2:0]        target_pos;
        logic [2:0]        logic_index;
        logic [1:0]        cond_index;
        logic [1:0]        obs_index;
        logic [3:0]        rel_time;
        logic [1:0]        obs_set;
        logic [2:0]        obs_pos;
        logic signed [7:0] value;
        logic [31:0]       timestamp;
    } req_word_t;

    typedef struct packed {
        logic signed [7:0] outcome;
        logic              matched;
        logic [2:0]        matched_logic;
        logic [1:0]        status;
    } rsp_word_t;

    typedef struct packed {
        logic       capture;
        logic       clr_step;
        logic       commit_step;
        logic       cfg_write;
        logic       q_init;
        logic       rd_cc;
        logic       rd_oc;
        logic       rd_obs;
        logic       rd_hist;
        logic       rd_out;
        logic       ld_nc;
        logic       ld_no;
        logic       next_logic;
        logic       to_default;
        logic       next_cond;
        logic       next_obs;
        logic       hit;
        logic       set_status;
        logic [1:0] status;
        logic       ld_result;
        logic       ld_rsp;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic commit_last;
        logic fc_full;
        logic n_zero;
        logic n_one;
        logic future;
        logic l_is_one;
        logic cond_end;
        logic obs_end;
        logic obs_bad;
        logic obs_before;
        logic early_eq;
        logic obs_evict;
        logic hist_eq;
    } dp_stat_t;

    // Count clamp: negatives give zero, anything above the maximum gives the maximum.
    function automatic logic [3:0] clamp_cnt(logic signed [7:0] v, logic [3:0] mx);
        logic [3:0] r;
        if (v < 0)
        begin
            r = 4'd0;
        end
        else if (v > $signed({4'b0000, mx}))
        begin
            r = mx;
        end
        else
        begin
            r = v[3:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/prmh_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module prmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/prmh_dp.sv =====
// Datapath of the rule matcher: frame and rule stores, walk indices and result registers.
`timescale 1ns / 1ps
`default_nettype none
module prmh_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire prmh_pkg::req_word_t req,
    input  wire prmh_pkg::ctl_cmd_t  ctl,
    output prmh_pkg::dp_stat_t       stat,
    output prmh_pkg::rsp_word_t      rsp
);
    import prmh_pkg::*;

    req_word_t   req_reg;
    logic [7:0]  fb_reg [NTARGETS];
    logic [3:0]  lcnt_reg [NTARGETS];
    logic [31:0] fc_reg;
    logic [9:0]  sweep_reg;
    logic [2:0]  l_reg;
    logic [2:0]  c_reg;
    logic [2:0]  o_reg;
    logic [2:0]  nc_reg;
    logic [2:0]  no_reg;
    logic [31:0] age_reg;
    logic        matched_reg;
    rsp_word_t   res_reg;
    rsp_word_t   rsp_reg;

    logic             tok;
    logic [4:0]       tgt;
    logic [3:0]       n;
    logic [7:0]       hist_rdata;
    logic [OBS_W-1:0] obs_rdata;
    logic [2:0]       oc_rdata;
    logic [2:0]       cc_rdata;
    logic [7:0]       out_rdata;
    logic [3:0]       ob_rel;
    logic [1:0]       ob_set;
    logic [2:0]       ob_pos;
    logic [3:0]       f_low;
    logic [8:0]       hist_waddr;
    logic [8:0]       hist_raddr;
    logic             wr_store;
    logic             wr_obs;
    logic             wr_ocnt;
    logic             wr_ccnt;
    logic             wr_out;
    logic             wr_lcnt;
    logic             oc_we;
    logic [9:0]       oc_waddr;
    logic [2:0]       oc_wdata;
    logic             cc_we;
    logic [7:0]       cc_waddr;
    logic [2:0]       cc_wdata;
    logic [3:0]       cnt_obs;
    logic [3:0]       cnt_cond;

    assign tok = req_reg.target_set < 2'(SETS);
    assign tgt = {req_reg.target_set, req_reg.target_pos};
    assign n   = tok ? lcnt_reg[tgt] : 4'd0;

    always_comb
    begin
        wr_store = 1'b0;
        wr_obs   = 1'b0;
        wr_ocnt  = 1'b0;
        wr_ccnt  = 1'b0;
        wr_out   = 1'b0;
        wr_lcnt  = 1'b0;
        unique case (req_reg.cmd)
            CMD_STORE:   wr_store = ctl.cfg_write && tok;
            CMD_OBS:     wr_obs   = ctl.cfg_write && tok;
            CMD_OCNT:    wr_ocnt  = ctl.cfg_write && tok;
            CMD_CCNT:    wr_ccnt  = ctl.cfg_write && tok;
            CMD_OUTCOME: wr_out   = ctl.cfg_write && tok;
            CMD_LCNT:    wr_lcnt  = ctl.cfg_write && tok;
            CMD_COMMIT, CMD_QUERY:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign cnt_obs  = clamp_cnt(req_reg.value, 4'(MAX_OBSERVATIONS));
    assign cnt_cond = clamp_cnt(req_reg.value, 4'(MAX_CONDITIONS));

    assign oc_we    = ctl.clr_step || wr_ocnt;
    assign oc_waddr = ctl.clr_step ? sweep_reg
                                   : {tgt, req_reg.logic_index, req_reg.cond_index};
    assign oc_wdata = ctl.clr_step ? 3'd0 : cnt_obs[2:0];
    assign cc_we    = (ctl.clr_step && sweep_reg < 10'(NLOGICS)) || wr_ccnt;
    assign cc_waddr = ctl.clr_step ? sweep_reg[7:0] : {tgt, req_reg.logic_index};
    assign cc_wdata = ctl.clr_step ? 3'd0 : cnt_cond[2:0];

    assign ob_pos = obs_rdata[10:8];
    assign ob_set = obs_rdata[12:11];
    assign ob_rel = obs_rdata[16:13];
    assign f_low  = req_reg.timestamp[3:0] - ob_rel;

    assign hist_waddr = 9'(fc_reg[3:0]) * 9'(NTARGETS) + 9'(sweep_reg[4:0]);
    assign hist_raddr = 9'(f_low) * 9'(NTARGETS) + 9'({ob_set, ob_pos});

    prmh_ram #(.WIDTH(8), .DEPTH(HIST_WORDS)) u_hist (
        .clk(clk), .we(ctl.commit_step), .waddr(hist_waddr),
        .wdata(fb_reg[sweep_reg[4:0]]), .re(ctl.rd_hist), .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    prmh_ram #(.WIDTH(OBS_W), .DEPTH(NOBS)) u_obs (
        .clk(clk), .we(wr_obs),
        .waddr({tgt, req_reg.logic_index, req_reg.cond_index, req_reg.obs_index}),
        .wdata({req_reg.rel_time, req_reg.obs_set, req_reg.obs_pos, req_reg.value}),
        .re(ctl.rd_obs), .raddr({tgt, l_reg, c_reg[1:0], o_reg[1:0]}),
        .rdata(obs_rdata)
    );

    prmh_ram #(.WIDTH(3), .DEPTH(NCONDS)) u_ocnt (
        .clk(clk), .we(oc_we), .waddr(oc_waddr), .wdata(oc_wdata),
        .re(ctl.rd_oc), .raddr({tgt, l_reg, c_reg[1:0]}), .rdata(oc_rdata)
    );

    prmh_ram #(.WIDTH(3), .DEPTH(NLOGICS)) u_ccnt (
        .clk(clk), .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
        .re(ctl.rd_cc), .raddr({tgt, l_reg}), .rdata(cc_rdata)
    );

    prmh_ram #(.WIDTH(8), .DEPTH(NLOGICS)) u_out (
        .clk(clk), .we(wr_out), .waddr({tgt, req_reg.logic_index}),
        .wdata(req_reg.value), .re(ctl.rd_out), .raddr({tgt, l_reg}),
        .rdata(out_rdata)
    );

    always_comb
    begin
        stat.clr_last    = sweep_reg == 10'(NCONDS - 1);
        stat.commit_last = sweep_reg == 10'(NTARGETS - 1);
        stat.fc_full     = fc_reg == 32'hFFFF_FFFF;
        stat.n_zero      = n == 4'd0;
        stat.n_one       = n == 4'd1;
        stat.future      = req_reg.timestamp >= fc_reg;
        stat.l_is_one    = l_reg == 3'd1;
        stat.cond_end    = c_reg >= nc_reg;
        stat.obs_end     = o_reg >= no_reg;
        stat.obs_bad     = ob_set >= 2'(SETS) || 4'(ob_pos) >= 4'(POSITIONS);
        stat.obs_before  = req_reg.timestamp < 32'(ob_rel);
        stat.early_eq    = obs_rdata[7:0] == 8'hFF;
        stat.obs_evict   = ({1'b0, age_reg} + 33'(ob_rel)) > 33'(HISTORY_DEPTH);
        stat.hist_eq     = hist_rdata == obs_rdata[7:0];
    end

    assign rsp = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg      <= '0;
            sweep_reg   <= '0;
            l_reg       <= '0;
            c_reg       <= '0;
            o_reg       <= '0;
            nc_reg      <= '0;
            no_reg      <= '0;
            matched_reg <= 1'b0;
            for (int i = 0; i < NTARGETS; i++)
            begin
                fb_reg[i]   <= '0;
                lcnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.clr_step)
            begin
                sweep_reg <= stat.clr_last ? 10'd0 : sweep_reg + 10'd1;
            end
            if (ctl.commit_step)
            begin
                if (stat.commit_last)
                begin
                    sweep_reg <= 10'd0;
                    fc_reg    <= fc_reg + 32'd1;
                end
                else
                begin
                    sweep_reg <= sweep_reg + 10'd1;
                end
            end
            if (wr_store)
            begin
                fb_reg[tgt] <= req_reg.value;
            end
            if (wr_lcnt)
            begin
                lcnt_reg[tgt] <= clamp_cnt(req_reg.value, 4'(MAX_LOGICS));
            end
            if (ctl.q_init)
            begin
                l_reg       <= 3'(n - 4'd1);
                matched_reg <= 1'b0;
            end
            if (ctl.rd_cc)
            begin
                c_reg <= 3'd0;
            end
            if (ctl.rd_oc)
            begin
                o_reg <= 3'd0;
            end
            if (ctl.ld_nc)
            begin
                nc_reg <= cc_rdata;
            end
            if (ctl.ld_no)
            begin
                no_reg <= oc_rdata;
            end
            if (ctl.next_logic)
            begin
                l_reg <= l_reg - 3'd1;
            end
            if (ctl.to_default)
            begin
                l_reg <= 3'd0;
            end
            if (ctl.next_cond)
            begin
                c_reg <= c_reg + 3'd1;
            end
            if (ctl.next_obs)
            begin
                o_reg <= o_reg + 3'd1;
            end
            if (ctl.hit)
            begin
                matched_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req;
        end
        if (ctl.q_init)
        begin
            age_reg <= fc_reg - req_reg.timestamp;
        end
        if (ctl.set_status)
        begin
            res_reg <= '{outcome: 8'sd0, matched: 1'b0, matched_logic: 3'd0,
                         status: ctl.status};
        end
        if (ctl.ld_result)
        begin
            res_reg <= '{outcome: out_rdata, matched: matched_reg, matched_logic: l_reg,
                         status: ST_OK};
        end
        if (ctl.ld_rsp)
        begin
            rsp_reg <= res_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/prmh_ctrl.sv =====
// Controller of the rule matcher: sequences clearing, commits, writes and the query walk.
`timescale 1ns / 1ps
`default_nettype none
module prmh_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [2:0]         req_cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    input  wire prmh_pkg::dp_stat_t stat,
    output prmh_pkg::ctl_cmd_t      ctl
);
    import prmh_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_COMMIT, S_QCHK, S_RDCC, S_WCC, S_CONDCHK,
        S_WOC, S_OBSCHK, S_WOBS, S_WHIST, S_RDOUT, S_WOUT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    priority if (req_cmd == CMD_QUERY)
                    begin
                        state_next = S_QCHK;
                    end
                    else if (req_cmd == CMD_COMMIT)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                ctl.cfg_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_COMMIT:
            begin
                if (stat.fc_full)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.commit_step = 1'b1;
                    if (stat.commit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_QCHK:
            begin
                ctl.q_init = 1'b1;
                priority if (stat.n_zero)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_NO_LOGIC;
                    state_next     = S_DONE;
                end
                else if (stat.future)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_FUTURE;
                    state_next     = S_DONE;
                end
                else if (stat.n_one)
                begin
                    state_next = S_RDOUT;
                end
                else
                begin
                    state_next = S_RDCC;
                end
            end
            S_RDCC:
            begin
                ctl.rd_cc  = 1'b1;
                state_next = S_WCC;
            end
            S_WCC:
            begin
                ctl.ld_nc  = 1'b1;
                state_next = S_CONDCHK;
            end
            S_CONDCHK:
            begin
                if (stat.cond_end)
                begin
                    if (stat.l_is_one)
                    begin
                        ctl.to_default = 1'b1;
                        state_next     = S_RDOUT;
                    end
                    else
                    begin
                        ctl.next_logic = 1'b1;
                        state_next     = S_RDCC;
                    end
                end
                else
                begin
                    ctl.rd_oc  = 1'b1;
                    state_next = S_WOC;
                end
            end
            S_WOC:
            begin
                ctl.ld_no  = 1'b1;
                state_next = S_OBSCHK;
            end
            S_OBSCHK:
            begin
                if (stat.obs_end)
                begin
                    ctl.hit    = 1'b1;
                    state_next = S_RDOUT;
                end
                else
                begin
                    ctl.rd_obs = 1'b1;
                    state_next = S_WOBS;
                end
            end
            S_WOBS:
            begin
                priority if (stat.obs_bad)
                begin
                    ctl.next_cond = 1'b1;
                    state_next    = S_CONDCHK;
                end
                else if (stat.obs_before)
                begin
                    if (stat.early_eq)
                    begin
                        ctl.next_obs = 1'b1;
                        state_next   = S_OBSCHK;
                    end
                    else
                    begin
                        ctl.next_cond = 1'b1;
                        state_next    = S_CONDCHK;
                    end
                end
                else if (stat.obs_evict)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_EVICTED;
                    state_next     = S_DONE;
                end
                else
                begin
                    ctl.rd_hist = 1'b1;
                    state_next  = S_WHIST;
                end
            end
            S_WHIST:
            begin
                if (stat.hist_eq)
                begin
                    ctl.next_obs = 1'b1;
                    state_next   = S_OBSCHK;
                end
                else
                begin
                    ctl.next_cond = 1'b1;
                    state_next    = S_CONDCHK;
                end
            end
            S_RDOUT:
            begin
                ctl.rd_out = 1'b1;
                state_next = S_WOUT;
            end
            S_WOUT:
            begin
                ctl.ld_result = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctl.ld_rsp     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/priority_rule_matcher_over_history_unit.sv =====
// Top level of the priority rule matcher over a window of history frames.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one request word at a time and answers queries with one response word.
// After reset it runs a clearing pass over all 768 entries of the observation count memory
// (the condition count memory is cleared in the same pass) and holds req_stall high
// throughout. A rule or staging write is done in the write state; a commit copies
// the 24 staged values into the history memory one per cycle through its single write
// port, unless the frame counter is full. A query that is flagged at once goes straight
// to the response; otherwise the controller walks the logics, their conditions and their
// observations, since every condition count, observation count, observation and history
// value is a separate registered memory read issued by the controller. The response
// sits in an output register, so a new word is accepted while an earlier response still
// waits for the consumer.
module priority_rule_matcher_over_history_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire prmh_pkg::req_word_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output prmh_pkg::rsp_word_t      rsp
);
    import prmh_pkg::*;

    `include "priority_rule_matcher_over_history_unit_assert.svh"

    ctl_cmd_t ctl;
    dp_stat_t stat;

    // The controller only sequences; all memories and the status comparisons live in the datapath.
    prmh_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req_cmd(req.cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .stat(stat), .ctl(ctl)
    );

    prmh_dp u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .ctl(ctl), .stat(stat), .rsp(rsp)
    );

    // Every accepted word keeps the block busy for at least the following cycle.
    `PRMH_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
        "block took a second word right after the first")

    // A flagged response never carries an outcome or a logic index.
    `PRMH_ASSERT_IMPLIES(a_flag_clean, rsp_valid && rsp.status != ST_OK,
        rsp.outcome == 8'sd0 && !rsp.matched && rsp.matched_logic == 3'd0,
        "flagged response carries match data")

    // A match is only reported for a logic above the default one.
    `PRMH_ASSERT_IMPLIES(a_match_logic, rsp_valid && rsp.matched,
        rsp.matched_logic != 3'd0 && rsp.status == ST_OK,
        "match reported for the default logic")

    // The walk issues at most one memory read per cycle.
    `PRMH_ASSERT_IMPLIES(a_one_read, 1'b1,
        $onehot0({ctl.rd_cc, ctl.rd_oc, ctl.rd_obs, ctl.rd_hist, ctl.rd_out}),
        "more than one rule memory read in a cycle")

endmodule
`default_nettype wire

// ===== dv/prmh_history_checker.sv =====
// Checker that predicts and compares the response words of the priority rule matcher.
`timescale 1ns / 1ps
module prmh_history_checker
    import prmh_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire logic      req_stall,
    input  wire req_word_t req,
    input  wire logic      rsp_valid,
    input  wire logic      rsp_stall,
    input  wire rsp_word_t rsp,
    output int             fails,
    output int             pending
);

    typedef struct packed {
        logic [3:0]        rel;
        logic [1:0]        oset;
        logic [2:0]        opos;
        logic signed [7:0] val;
    } rule_obs_t;

    typedef enum logic [1:0] {OBS_MISS, OBS_HIT, OBS_GONE} obs_verdict_e;

    logic signed [7:0] frames [HISTORY_DEPTH][SETS][POSITIONS];
    logic signed [7:0] staging [SETS][POSITIONS];
    logic [31:0]       frames_done;
    rule_obs_t         obs_mem [NOBS];
    logic [3:0]        obs_cnt [NCONDS];
    logic [3:0]        cond_cnt [NLOGICS];
    logic signed [7:0] outcomes [NLOGICS];
    logic [3:0]        logic_cnt [NTARGETS];
    rsp_word_t         answers_due [$];

    function automatic logic [3:0] sat_count(logic signed [7:0] v, int mx);
        logic [3:0] r;
        if (v < 0)
            r = 4'd0;
        else if (int'(v) > mx)
            r = 4'(mx);
        else
            r = 4'(v);
        return r;
    endfunction

    function automatic obs_verdict_e judge_obs(logic [31:0] ts, rule_obs_t ob);
        logic [31:0]       f;
        logic signed [7:0] seen;
        if (ob.oset >= SETS || ob.opos >= POSITIONS)
            return OBS_MISS;
        if (ts < 32'(ob.rel))
        begin
            seen = -8'sd1;
        end
        else
        begin
            f = ts - 32'(ob.rel);
            if (frames_done - f > 32'(HISTORY_DEPTH))
                return OBS_GONE;
            seen = frames[f % HISTORY_DEPTH][ob.oset][ob.opos];
        end
        return (seen == ob.val) ? OBS_HIT : OBS_MISS;
    endfunction

    function automatic rsp_word_t answer_query(req_word_t w);
        rsp_word_t    a;
        int           tgt, n, lg, cd;
        bit           done, all;
        obs_verdict_e v;
        a = '0;
        done = 0;
        tgt = int'(w.target_set) * POSITIONS + int'(w.target_pos);
        n = (w.target_set < SETS) ? int'(logic_cnt[tgt]) : 0;
        if (n == 0)
        begin
            a.status = ST_NO_LOGIC;
        end
        else if (w.timestamp >= frames_done)
        begin
            a.status = ST_FUTURE;
        end
        else
        begin
            a.status = ST_OK;
            for (int l = n - 1; l > 0 && !done; l--)
            begin
                lg = tgt * MAX_LOGICS + l;
                for (int c = 0; c < int'(cond_cnt[lg]) && !done; c++)
                begin
                    cd = lg * MAX_CONDITIONS + c;
                    all = 1;
                    for (int o = 0; o < int'(obs_cnt[cd]); o++)
                    begin
                        v = judge_obs(w.timestamp, obs_mem[cd * MAX_OBSERVATIONS + o]);
                        if (v == OBS_GONE)
                        begin
                            a.status = ST_EVICTED;
                            done = 1;
                            all = 0;
                            break;
                        end
                        if (v == OBS_MISS)
                        begin
                            all = 0;
                            break;
                        end
                    end
                    if (all)
                    begin
                        done = 1;
                        a.matched = 1'b1;
                        a.matched_logic = 3'(l);
                        a.outcome = outcomes[lg];
                    end
                end
            end
            if (!done)
                a.outcome = outcomes[tgt * MAX_LOGICS];
            if (a.status != ST_OK)
            begin
                a.outcome = '0;
                a.matched = 1'b0;
                a.matched_logic = '0;
            end
        end
        return a;
    endfunction

    task automatic report(string what, int got, int want);
        fails++;
        if (fails <= 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int        tgt, lg, cd;
        rsp_word_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
                for (int p = 0; p < POSITIONS; p++)
                    staging[s][p] = '0;
            frames_done = '0;
            for (int i = 0; i < NCONDS; i++)
                obs_cnt[i] = '0;
            for (int i = 0; i < NLOGICS; i++)
                cond_cnt[i] = '0;
            for (int i = 0; i < NTARGETS; i++)
                logic_cnt[i] = '0;
            answers_due.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    report("unexpected response word", int'(rsp), 0);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.outcome != want.outcome)
                        report("outcome", int'(rsp.outcome), int'(want.outcome));
                    if (rsp.matched != want.matched)
                        report("matched", int'(rsp.matched), int'(want.matched));
                    if (rsp.matched_logic != want.matched_logic)
                        report("matched_logic", int'(rsp.matched_logic),
                               int'(want.matched_logic));
                    if (rsp.status != want.status)
                        report("status", int'(rsp.status), int'(want.status));
                end
            end
            if (req_valid && !req_stall)
            begin
                tgt = int'(req.target_set) * POSITIONS + int'(req.target_pos);
                lg = tgt * MAX_LOGICS + int'(req.logic_index);
                cd = lg * MAX_CONDITIONS + int'(req.cond_index);
                if (req.cmd == CMD_QUERY)
                begin
                    answers_due = {answers_due, answer_query(req)};
                end
                else if (req.cmd == CMD_COMMIT)
                begin
                    if (frames_done != 32'hFFFF_FFFF)
                    begin
                        frames[frames_done % HISTORY_DEPTH] = staging;
                        frames_done++;
                    end
                end
                else if (req.target_set < SETS)
                begin
                    case (req.cmd)
                        CMD_STORE:   staging[req.target_set][req.target_pos] = req.value;
                        CMD_OBS:     obs_mem[cd * MAX_OBSERVATIONS + int'(req.obs_index)] =
                                         {req.rel_time, req.obs_set, req.obs_pos, req.value};
                        CMD_OCNT:    obs_cnt[cd] = sat_count(req.value, MAX_OBSERVATIONS);
                        CMD_CCNT:    cond_cnt[lg] = sat_count(req.value, MAX_CONDITIONS);
                        CMD_OUTCOME: outcomes[lg] = req.value;
                        CMD_LCNT:    logic_cnt[tgt] = sat_count(req.value, MAX_LOGICS);
                        default:     ;
                    endcase
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

// ===== dv/tb_priority_rule_matcher_over_history_unit.sv =====
// Testbench top of the priority rule matcher: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb_priority_rule_matcher_over_history_unit;
    import prmh_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;
    int        fails;
    int        pending;

    // Generator bookkeeping. It only tracks which rule entries hold a written value
    // and what the counts are, so that a query never walks into an unwritten entry.
    logic [3:0]  gen_lcnt [NTARGETS];
    logic [3:0]  gen_ccnt [NLOGICS];
    logic [3:0]  gen_ocnt [NCONDS];
    bit          outcome_set [NLOGICS];
    bit          obs_set_flag [NOBS];
    logic [31:0] gen_frames;
    int          words_sent;
    bit          quiet;
    bit          hold_req;
    bit          hold_done;
    bit          drain_done;

    always #6 clk = ~clk;

    priority_rule_matcher_over_history_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    prmh_history_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .fails     (fails),
        .pending   (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [3:0] gen_sat(logic signed [7:0] v, int mx);
        if (v < 0)
            return 4'd0;
        if (int'(v) > mx)
            return 4'(mx);
        return 4'(v);
    endfunction

    // Values drawn mostly from a tiny alphabet around -1 so that observations hit often.
    function automatic logic signed [7:0] near_value();
        if ($urandom_range(0, 9) < 8)
            return 8'(int'($urandom_range(0, 3)) - 1);
        return 8'($urandom);
    endfunction

    function automatic logic signed [7:0] count_value(int mx);
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, mx + 1));
        return 8'($urandom);
    endfunction

    // A word with every field random; callers override what matters.
    function automatic req_word_t noise_word();
        req_word_t w;
        w = {$urandom, $urandom};
        return w;
    endfunction

    // Targets are focused on a few so that rules build up, with stray ones too.
    function automatic req_word_t aim(req_word_t w);
        if ($urandom_range(0, 9) < 8)
        begin
            w.target_set = 2'($urandom_range(0, 1));
            w.target_pos = 3'($urandom_range(0, 2));
        end
        return w;
    endfunction

    function automatic logic [31:0] pick_stamp();
        int          r;
        logic [31:0] back;
        r = $urandom_range(0, 99);
        if (gen_frames == 0 || r < 8)
            return $urandom;
        if (r < 16)
            return gen_frames + 32'($urandom_range(0, 3));
        if (r < 70)
            back = 32'($urandom_range(0, 4));
        else
            back = 32'($urandom_range(0, 30));
        if (back >= gen_frames)
            return 32'd0;
        return gen_frames - 32'd1 - back;
    endfunction

    // Sends one word, keeps the bookkeeping in step, then idles for a random gap.
    task automatic push_word(input req_word_t w);
        int tgt, lg, cd, g;
        tgt = int'(w.target_set) * POSITIONS + int'(w.target_pos);
        lg = tgt * MAX_LOGICS + int'(w.logic_index);
        cd = lg * MAX_CONDITIONS + int'(w.cond_index);
        if (w.cmd == CMD_COMMIT)
        begin
            if (gen_frames != 32'hFFFF_FFFF)
                gen_frames++;
        end
        else if (w.cmd != CMD_QUERY && w.target_set < SETS)
        begin
            case (w.cmd)
                CMD_OBS:     obs_set_flag[cd * MAX_OBSERVATIONS + int'(w.obs_index)] = 1;
                CMD_OCNT:    gen_ocnt[cd] = gen_sat(w.value, MAX_OBSERVATIONS);
                CMD_CCNT:    gen_ccnt[lg] = gen_sat(w.value, MAX_CONDITIONS);
                CMD_OUTCOME: outcome_set[lg] = 1;
                CMD_LCNT:    gen_lcnt[tgt] = gen_sat(w.value, MAX_LOGICS);
                default:     ;
            endcase
        end
        req <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        words_sent++;
        g = quiet ? 0 : pick_gap();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Writes every outcome and observation that a query of this target could read.
    task automatic fill_target(input logic [1:0] tset, input logic [2:0] tpos);
        req_word_t w;
        int        tgt, lg, cd;
        if (tset >= SETS)
            return;
        tgt = int'(tset) * POSITIONS + int'(tpos);
        for (int l = 0; l < int'(gen_lcnt[tgt]); l++)
        begin
            lg = tgt * MAX_LOGICS + l;
            if (!outcome_set[lg])
            begin
                w = noise_word();
                w.cmd = CMD_OUTCOME;
                w.target_set = tset;
                w.target_pos = tpos;
                w.logic_index = 3'(l);
                push_word(w);
            end
            if (l > 0)
            begin
                for (int c = 0; c < int'(gen_ccnt[lg]); c++)
                begin
                    cd = lg * MAX_CONDITIONS + c;
                    for (int o = 0; o < int'(gen_ocnt[cd]); o++)
                    begin
                        if (!obs_set_flag[cd * MAX_OBSERVATIONS + o])
                        begin
                            w = noise_word();
                            w.cmd = CMD_OBS;
                            w.target_set = tset;
                            w.target_pos = tpos;
                            w.logic_index = 3'(l);
                            w.cond_index = 2'(c);
                            w.obs_index = 2'(o);
                            w.rel_time = 4'($urandom_range(0, 3));
                            w.obs_set = 2'($urandom_range(0, 2));
                            w.obs_pos = 3'($urandom_range(0, 1));
                            w.value = near_value();
                            push_word(w);
                        end
                    end
                end
            end
        end
    endtask

    task automatic ask(input req_word_t w);
        w.cmd = CMD_QUERY;
        fill_target(w.target_set, w.target_pos);
        push_word(w);
    endtask

    task automatic put(input logic [2:0] cmd, input logic [1:0] tset, input logic [2:0] tpos,
                       input logic [2:0] li, input logic [1:0] ci,
                       input logic signed [7:0] v);
        req_word_t w;
        w = noise_word();
        w.cmd = cmd;
        w.target_set = tset;
        w.target_pos = tpos;
        w.logic_index = li;
        w.cond_index = ci;
        w.value = v;
        push_word(w);
    endtask

    task automatic query_at(input logic [1:0] tset, input logic [2:0] tpos,
                            input logic [31:0] ts);
        req_word_t w;
        w = noise_word();
        w.target_set = tset;
        w.target_pos = tpos;
        w.timestamp = ts;
        ask(w);
    endtask

    // Random word of one kind, mostly aimed at the busy targets.
    task automatic random_word();
        req_word_t w;
        int        r;
        w = aim(noise_word());
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            w.cmd = CMD_STORE;
            w.obs_pos = 3'($urandom_range(0, 1));
            w.target_pos = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 1)) : w.target_pos;
            w.target_set = ($urandom_range(0, 9) != 0) ? 2'($urandom_range(0, 2)) : w.target_set;
            w.value = near_value();
            push_word(w);
        end
        else if (r < 21)
        begin
            w.cmd = CMD_COMMIT;
            push_word(w);
        end
        else if (r < 40)
        begin
            w.cmd = CMD_OBS;
            if ($urandom_range(0, 9) < 8)
            begin
                w.rel_time = 4'($urandom_range(0, 3));
                w.obs_set = 2'($urandom_range(0, 2));
                w.obs_pos = 3'($urandom_range(0, 1));
                w.value = near_value();
            end
            push_word(w);
        end
        else if (r < 50)
        begin
            w.cmd = CMD_OCNT;
            w.value = count_value(MAX_OBSERVATIONS);
            push_word(w);
        end
        else if (r < 58)
        begin
            w.cmd = CMD_CCNT;
            w.value = count_value(MAX_CONDITIONS);
            push_word(w);
        end
        else if (r < 64)
        begin
            w.cmd = CMD_OUTCOME;
            push_word(w);
        end
        else if (r < 70)
        begin
            w.cmd = CMD_LCNT;
            w.value = count_value(MAX_LOGICS);
            push_word(w);
        end
        else
        begin
            w.timestamp = pick_stamp();
            ask(w);
        end
    endtask

    // Receiver side: runs of stall and no stall, a quiet stretch on request, and
    // one long hold-off counted here while the sender keeps pushing words.
    initial
    begin
        int  run_left;
        bit  stalling;
        run_left = 0;
        stalling = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_req = 0;
            end
            else if (quiet)
            begin
                rsp_stall <= 1'b0;
                run_left = 0;
            end
            else if (run_left == 0)
            begin
                stalling = !stalling;
                run_left = pick_gap() + 1;
                rsp_stall <= stalling;
            end
            else
            begin
                run_left--;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("priority_rule_matcher_over_history_unit verification failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < NTARGETS; i++)
            gen_lcnt[i] = '0;
        for (int i = 0; i < NLOGICS; i++)
        begin
            gen_ccnt[i] = '0;
            outcome_set[i] = 0;
        end
        for (int i = 0; i < NCONDS; i++)
            gen_ocnt[i] = '0;
        for (int i = 0; i < NOBS; i++)
            obs_set_flag[i] = 0;
        gen_frames = '0;
        words_sent = 0;
        quiet = 0;
        hold_req = 0;
        hold_done = 0;
        drain_done = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A target without logic entries and one out of range both
        // answer "no logic"; a query before any commit lies in the future.
        query_at(2'd0, 3'd0, 32'd0);
        query_at(2'd3, 3'd7, 32'hFFFF_FFFF);
        put(CMD_LCNT, 2'd0, 3'd0, 3'd0, 2'd0, -8'sd128);
        query_at(2'd0, 3'd0, 32'd0);
        put(CMD_LCNT, 2'd0, 3'd0, 3'd0, 2'd0, 8'sd127);
        query_at(2'd0, 3'd0, 32'd0);
        // Staged extremes, committed twice so that the staging buffer is seen to persist.
        put(CMD_STORE, 2'd2, 3'd7, 3'd0, 2'd0, -8'sd128);
        put(CMD_STORE, 2'd0, 3'd0, 3'd0, 2'd0, 8'sd127);
        put(CMD_COMMIT, 2'd0, 3'd0, 3'd0, 2'd0, 8'sd0);
        put(CMD_COMMIT, 2'd0, 3'd0, 3'd0, 2'd0, 8'sd0);
        // Logic 7 with an empty condition matches at once; a single logic answers with the default.
        put(CMD_CCNT, 2'd0, 3'd0, 3'd7, 2'd0, 8'sd1);
        put(CMD_OCNT, 2'd0, 3'd0, 3'd7, 2'd0, 8'sd0);
        put(CMD_OUTCOME, 2'd0, 3'd0, 3'd7, 2'd0, -8'sd128);
        query_at(2'd0, 3'd0, 32'd1);
        put(CMD_CCNT, 2'd0, 3'd0, 3'd7, 2'd0, -8'sd1);
        put(CMD_LCNT, 2'd1, 3'd4, 3'd0, 2'd0, 8'sd1);
        query_at(2'd1, 3'd4, 32'd0);
        // A second target with two logics, queried at two timestamps.
        put(CMD_LCNT, 2'd2, 3'd7, 3'd0, 2'd0, 8'sd2);
        put(CMD_CCNT, 2'd2, 3'd7, 3'd1, 2'd0, 8'sd100);
        put(CMD_OCNT, 2'd2, 3'd7, 3'd1, 2'd3, 8'sd5);
        query_at(2'd2, 3'd7, 32'd0);
        query_at(2'd2, 3'd7, 32'd2);
        // Enough commits to push early frames out of the window, then a stale query.
        repeat (18) put(CMD_COMMIT, 2'd0, 3'd0, 3'd0, 2'd0, 8'sd0);
        query_at(2'd2, 3'd7, 32'd1);
        query_at(2'd0, 3'd0, 32'd0);

        // Random part with quiet stretches, a long receiver hold and a full drain.
        while (words_sent < 1900)
        begin
            quiet = (words_sent % 600) >= 480;
            if (!hold_done && words_sent >= 700)
            begin
                hold_req = 1;
                hold_done = 1;
            end
            if (!drain_done && words_sent >= 1200)
            begin
                drain_done = 1;
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            random_word();
        end
        req_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (fails == 0)
            $display("priority_rule_matcher_over_history_unit verification clean");
        else
            $display("priority_rule_matcher_over_history_unit verification failed");
        $finish;
    end

endmodule
